/* hw/rtl/note_to_piecewise_linear_value_core_assert.svh */
// Assertion macros for the note-to-value core.
// Both macros expect signals named clk and rst in the scope where they are used.
`ifndef NOTE_TO_PIECEWISE_LINEAR_VALUE_CORE_ASSERT_SVH
`define NOTE_TO_PIECEWISE_LINEAR_VALUE_CORE_ASSERT_SVH

// Same-cycle implication.
`define NTPLV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define NTPLV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ntplv_pkg.sv */
// Shared types and constants for the note-to-value core.
// No dependencies; imported by every module of the block.
package ntplv_pkg;

  localparam int DEF_NODE_COUNT    = 5;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int KEY_W      = 7;
  localparam int NODE_W     = 25;
  localparam int NODE_VAL_W = 18;
  localparam int VALUE_W    = 25;
  localparam int MODE_W     = 2;
  localparam int DIVR_W     = KEY_W + 1;
  localparam int PROD_W     = NODE_VAL_W + KEY_W + 1;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 25;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SOURCE_MODE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ROOT        = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPREAD      = 8'd2;
  localparam int                     CFG_IDX_NODE_BASE   = 3;

  localparam logic [KEY_W-1:0] RST_ROOT   = 7'd60;
  localparam logic [KEY_W-1:0] RST_SPREAD = 7'd12;

  // bit positions inside source_and_mode
  localparam int MODE_BIT_SOURCE   = 0;
  localparam int MODE_BIT_RELATIVE = 1;

  localparam longint VALUE_MAX = 64'sd16777215;

  typedef struct packed {
    logic capture;
    logic rel;
    logic search;
    logic fetch;
    logic mul;
    logic sum;
    logic div_start;
    logic emit;
    logic hit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode_rel;
    logic spread_zero;
    logic key_le;
    logic den_zero;
    logic div_done;
  } dp_status_t;

endpackage

/* hw/rtl/note_to_piecewise_linear_value_core.sv */
// Note-to-value core: maps a note-on key (note number or velocity) onto a
// signed fixed-point value, either relative to a root or along a
// piecewise linear curve of NODE_COUNT nodes, with a rounding divider.
// Uses ntplv_pkg, ntplv_ctrl, ntplv_dpath, ntplv_div and the assertion header.
//
// One note-on event at a time goes through the core. The divider width is
// max(7 + FRACTION_BITS, 25) + 3, which is 28 at the defaults. The restoring
// divider delivers one quotient bit a cycle, and in absolute mode the node
// search walks one node a cycle from the second-to-last node down. Items that
// find no node, meet two equal adjacent node keys or see a zero spread skip the
// divider and return the held value with matched low. The result sits in an
// output register, so a finished result may wait on m_tready while the core
// already takes the next event. Configuration must be written through the cfg
// port only while the core is idle; the core itself does not enforce this.
// Register i of the list has index i, and indexes beyond the node registers
// are dropped.
`include "note_to_piecewise_linear_value_core_assert.svh"

module note_to_piecewise_linear_value_core import ntplv_pkg::*; #(
  parameter int NODE_COUNT    = DEF_NODE_COUNT,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [15:0]            s_tdata,   // note_number[6:0], note_velocity[13:7], zero pad
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,   // mapped_value[24:0], used_key[31:25]
  output logic [0:0]             m_tuser,   // matched[0]
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int MAG_W  = ((KEY_W + FRACTION_BITS > PROD_W - 1) ?
                           KEY_W + FRACTION_BITS : PROD_W - 1) + 1;
  localparam int DVD_W  = MAG_W + 2;
  localparam int IDX_W  = $clog2(NODE_COUNT);

  // configuration registers
  logic [MODE_W-1:0] source_and_mode;
  logic [KEY_W-1:0]  relative_root;
  logic [KEY_W-1:0]  relative_spread;
  logic [NODE_W-1:0] nodes [NODE_COUNT];
  logic              cfg_we;

  // internal links
  ctrl_cmd_t                 dp_cmd;
  dp_status_t                dp_status;
  logic [IDX_W-1:0]          node_sel;
  logic                      out_free;
  logic [DVD_W-1:0]          div_dividend;
  logic [DIVR_W-1:0]         div_divisor;
  logic [DVD_W-1:0]          div_quotient;
  logic                      div_done;
  logic signed [VALUE_W-1:0] out_value;
  logic [KEY_W-1:0]          out_key;
  logic                      out_hit;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_and_mode <= '0;
      relative_root   <= RST_ROOT;
      relative_spread <= RST_SPREAD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_SOURCE_MODE: source_and_mode <= cfg_data[MODE_W-1:0];
        CFG_IDX_ROOT:        relative_root   <= cfg_data[KEY_W-1:0];
        CFG_IDX_SPREAD:      relative_spread <= cfg_data[KEY_W-1:0];
        default: begin
          // node writes are handled below; anything else is dropped
        end
      endcase
    end
  end

  // Node i resets to an evenly spaced key and a value running from -1 to +1.
  for (genvar i = 0; i < NODE_COUNT; i++) begin : g_node
    localparam longint NodeKey = (127 * i) / (NODE_COUNT - 1);
    localparam longint NodeVal = -(64'sd1 <<< FRACTION_BITS)
                                 + ((64'sd2 <<< FRACTION_BITS) * i) / (NODE_COUNT - 1);
    localparam logic [NODE_W-1:0] NodeRst = {KEY_W'(NodeKey), NODE_VAL_W'(NodeVal)};

    always_ff @(posedge clk) begin
      if (rst) begin
        nodes[i] <= NodeRst;
      end else if (cfg_we && (cfg_index == CFG_INDEX_W'(CFG_IDX_NODE_BASE + i))) begin
        nodes[i] <= cfg_data[NODE_W-1:0];
      end
    end
  end

  // The output register is free when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;

  ntplv_ctrl #(
    .NODE_COUNT (NODE_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .status   (dp_status),
    .in_ready (s_tready),
    .cmd      (dp_cmd),
    .node_sel (node_sel)
  );

  ntplv_dpath #(
    .NODE_COUNT    (NODE_COUNT),
    .FRACTION_BITS (FRACTION_BITS),
    .DVD_W         (DVD_W)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (dp_cmd),
    .node_sel        (node_sel),
    .note_number     (s_tdata[KEY_W-1:0]),
    .note_velocity   (s_tdata[2*KEY_W-1:KEY_W]),
    .source_and_mode (source_and_mode),
    .relative_root   (relative_root),
    .relative_spread (relative_spread),
    .nodes           (nodes),
    .status          (dp_status),
    .div_dividend    (div_dividend),
    .div_divisor     (div_divisor),
    .div_quotient    (div_quotient),
    .div_done        (div_done),
    .out_value       (out_value),
    .out_key         (out_key),
    .out_hit         (out_hit)
  );

  ntplv_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dp_cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // Hold the result until the consumer takes it; load a new one on emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (dp_cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit) begin
      m_tdata <= {out_key, out_value};
      m_tuser <= out_hit;
    end
  end

  // A second event must not enter while the first is still in flight.
  `NTPLV_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "event accepted while busy")
  // Never overwrite a result the consumer has not taken.
  `NTPLV_ASSERT_IMP(a_no_overwrite, dp_cmd.emit, out_free, "result register overwritten")
  // An emitted result shows up on the output in the following cycle.
  `NTPLV_ASSERT_NXT(a_emit_visible, dp_cmd.emit, m_tvalid, "emitted result not presented")

endmodule

/* hw/rtl/ntplv_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Uses ntplv_pkg for the divisor width.
module ntplv_div import ntplv_pkg::*; #(
  parameter int DVD_W = 28
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic [DVD_W-1:0]  quotient,
  output logic              done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  count;
  logic [DIVR_W-1:0] rem;
  logic [DVD_W-1:0]  quo;
  logic [DIVR_W-1:0] dvs;
  logic [DIVR_W:0]   shifted;
  logic [DIVR_W:0]   trial;

  assign shifted  = {rem, quo[DVD_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && (count == CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DVD_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[DIVR_W]) begin
        rem <= trial[DIVR_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIVR_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* hw/rtl/ntplv_ctrl.sv */
// Sequencer of the note-to-value core: node search or relative setup, product, divide, emit.
// Uses ntplv_pkg command and status structs.
module ntplv_ctrl import ntplv_pkg::*; #(
  parameter int NODE_COUNT = DEF_NODE_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          out_free,
  input  dp_status_t                    status,
  output logic                          in_ready,
  output ctrl_cmd_t                     cmd,
  output logic [$clog2(NODE_COUNT)-1:0] node_sel
);

  localparam int IDX_W = $clog2(NODE_COUNT);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_REL    = 4'd1;
  localparam logic [3:0] ST_SEARCH = 4'd2;
  localparam logic [3:0] ST_FETCH  = 4'd3;
  localparam logic [3:0] ST_MUL    = 4'd4;
  localparam logic [3:0] ST_SUM    = 4'd5;
  localparam logic [3:0] ST_START  = 4'd6;
  localparam logic [3:0] ST_DIV    = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  logic [3:0]       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             hit_flag, hit_flag_next;

  assign in_ready = (state == ST_IDLE);
  assign node_sel = (state == ST_FETCH) ? idx + IDX_W'(1) : idx;

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    hit_flag_next = hit_flag;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          idx_next    = IDX_W'(NODE_COUNT - 2);
          state_next  = status.mode_rel ? ST_REL : ST_SEARCH;
        end
      end
      ST_REL: begin
        if (status.spread_zero) begin
          hit_flag_next = 1'b0;
          state_next    = ST_DONE;
        end else begin
          cmd.rel    = 1'b1;
          state_next = ST_START;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (status.key_le) begin
          state_next = ST_FETCH;
        end else if (idx == '0) begin
          hit_flag_next = 1'b0;
          state_next    = ST_DONE;
        end else begin
          idx_next = idx - IDX_W'(1);
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (status.den_zero) begin
          hit_flag_next = 1'b0;
          state_next    = ST_DONE;
        end else begin
          cmd.mul    = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          hit_flag_next = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.hit = hit_flag;
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      hit_flag <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      hit_flag <= hit_flag_next;
    end
  end

endmodule

/* hw/rtl/ntplv_dpath.sv */
// Datapath of the note-to-value core: key capture, node read, products,
// divider operands, rounding sign, saturation and the held value.
// Uses ntplv_pkg; the divider sits beside it in the top level.
module ntplv_dpath import ntplv_pkg::*; #(
  parameter int NODE_COUNT    = DEF_NODE_COUNT,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int DVD_W         = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ctrl_cmd_t                     cmd,
  input  logic [$clog2(NODE_COUNT)-1:0] node_sel,
  input  logic [KEY_W-1:0]              note_number,
  input  logic [KEY_W-1:0]              note_velocity,
  input  logic [MODE_W-1:0]             source_and_mode,
  input  logic [KEY_W-1:0]              relative_root,
  input  logic [KEY_W-1:0]              relative_spread,
  input  logic [NODE_W-1:0]             nodes [NODE_COUNT],
  output dp_status_t                    status,
  output logic [DVD_W-1:0]              div_dividend,
  output logic [DIVR_W-1:0]             div_divisor,
  input  logic [DVD_W-1:0]              div_quotient,
  input  logic                          div_done,
  output logic signed [VALUE_W-1:0]     out_value,
  output logic [KEY_W-1:0]              out_key,
  output logic                          out_hit
);

  localparam int NUM_W = DVD_W - 1;
  localparam int MAG_W = DVD_W - 2;

  logic [KEY_W-1:0]             key_reg;
  logic [KEY_W-1:0]             k1, k2;
  logic signed [NODE_VAL_W-1:0] v1, v2;
  logic signed [PROD_W-1:0]     p1, p2;
  logic signed [NUM_W-1:0]      num;
  logic signed [DIVR_W-1:0]     den;
  logic                         neg;
  logic signed [VALUE_W-1:0]    held_value;
  logic [KEY_W-1:0]             held_key;

  logic [NODE_W-1:0]            node_rd;
  logic [KEY_W-1:0]             rd_key;
  logic signed [NODE_VAL_W-1:0] rd_val;
  logic signed [KEY_W:0]        rel_diff;
  logic signed [NUM_W-1:0]      rel_num;
  logic signed [KEY_W:0]        d_hi, d_lo;
  logic [NUM_W-1:0]             num_mag;
  logic [DIVR_W-1:0]            den_mag;
  logic                         pos_over, neg_over;
  logic signed [VALUE_W-1:0]    sat_value;

  assign node_rd = nodes[node_sel];
  assign rd_key  = node_rd[NODE_W-1 -: KEY_W];
  assign rd_val  = node_rd[NODE_VAL_W-1:0];

  assign rel_diff = $signed({1'b0, key_reg}) - $signed({1'b0, relative_root});
  assign rel_num  = {{(NUM_W-KEY_W-1){rel_diff[KEY_W]}}, rel_diff} <<< FRACTION_BITS;
  assign d_hi     = $signed({1'b0, k2}) - $signed({1'b0, key_reg});
  assign d_lo     = $signed({1'b0, key_reg}) - $signed({1'b0, k1});

  assign status.mode_rel    = source_and_mode[MODE_BIT_RELATIVE];
  assign status.spread_zero = (relative_spread == '0);
  assign status.key_le      = (rd_key <= key_reg);
  assign status.den_zero    = (k2 == k1);
  assign status.div_done    = div_done;

  // round to nearest, ties away: q = (2|n| + |d|) / (2|d|)
  assign num_mag      = num[NUM_W-1] ? -num : num;
  assign den_mag      = den[DIVR_W-1] ? -den : den;
  assign div_dividend = DVD_W'({num_mag[MAG_W-1:0], 1'b0}) + DVD_W'(den_mag[KEY_W-1:0]);
  assign div_divisor  = {den_mag[KEY_W-1:0], 1'b0};

  assign pos_over = (div_quotient > DVD_W'(VALUE_MAX));
  assign neg_over = (div_quotient > DVD_W'(VALUE_MAX + 1));

  always_comb begin
    if (neg) begin
      sat_value = neg_over ? -VALUE_W'(VALUE_MAX + 1) : -$signed(div_quotient[VALUE_W-1:0]);
    end else begin
      sat_value = pos_over ? VALUE_W'(VALUE_MAX) : $signed(div_quotient[VALUE_W-1:0]);
    end
  end

  assign out_value = cmd.hit ? sat_value : held_value;
  assign out_key   = cmd.hit ? key_reg : held_key;
  assign out_hit   = cmd.hit;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_reg <= source_and_mode[MODE_BIT_SOURCE] ? note_velocity : note_number;
    end
    if (cmd.search) begin
      k1 <= rd_key;
      v1 <= rd_val;
    end
    if (cmd.fetch) begin
      k2 <= rd_key;
      v2 <= rd_val;
    end
    if (cmd.mul) begin
      p1 <= PROD_W'(v1) * PROD_W'(d_hi);
      p2 <= PROD_W'(v2) * PROD_W'(d_lo);
    end
    if (cmd.sum) begin
      num <= {{(NUM_W-PROD_W){p1[PROD_W-1]}}, p1} + {{(NUM_W-PROD_W){p2[PROD_W-1]}}, p2};
      den <= $signed({1'b0, k2}) - $signed({1'b0, k1});
    end else if (cmd.rel) begin
      num <= rel_num;
      den <= $signed({1'b0, relative_spread});
    end
    if (cmd.div_start) begin
      neg <= num[NUM_W-1] ^ den[DIVR_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_value <= '0;
      held_key   <= '0;
    end else if (cmd.emit && cmd.hit) begin
      held_value <= sat_value;
      held_key   <= key_reg;
    end
  end

endmodule
